>>> hdl/ekls_pkg.sv
// shared types, constants and the quadrature transition function for the knob selector
`timescale 1ns / 1ps
`default_nettype none

package ekls_pkg;

    // field widths
    localparam int LEVEL_W  = 7;
    localparam int NUM_LEDS = 4;
    localparam int SEL_W    = 2;
    localparam int SUM_W    = 4;
    localparam int CFG_W    = 7;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 40;

    // configuration register indexes
    localparam logic CFG_STEP_SIZE = 1'b0;
    localparam logic CFG_MAX_LEVEL = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] STEP_SIZE_RST = 7'd10;
    localparam logic [CFG_W-1:0] MAX_LEVEL_RST = 7'd100;

    // detent direction codes
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_CW   = 2'sb01;
    localparam logic signed [1:0] DIR_CCW  = 2'sb11;

    // phase pair where both pins rest high
    localparam logic [1:0] PHASE_REST = 2'b11;

    // accumulator value that marks a full detent
    localparam logic signed [SUM_W-1:0] DETENT_CW  = 4'sd4;
    localparam logic signed [SUM_W-1:0] DETENT_CCW = -4'sd4;

    // accumulator bounds
    localparam logic signed [SUM_W:0] SUM_MAX = 5'sd7;
    localparam logic signed [SUM_W:0] SUM_MIN = -5'sd8;

    // status shown with every result
    typedef struct packed {
        logic                               menu_mode;
        logic [SEL_W-1:0]                   selection;
        logic [NUM_LEDS-1:0][LEVEL_W-1:0]   levels;
    } knob_status_t;

    // transition table: previous pair by current pair, diagonal jumps count zero
    function automatic logic signed [1:0] trans_delta(
        input logic [1:0] prev_phase,
        input logic [1:0] now_phase
    );
        logic signed [1:0] delta;
        unique case ({prev_phase, now_phase})
            4'b0001, 4'b0111, 4'b1000, 4'b1110: delta = DIR_CW;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: delta = DIR_CCW;
            default:                            delta = DIR_NONE;
        endcase
        return delta;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ekls_quad_decoder.sv
// quadrature decoder: transition accumulator and detent detection at the rest state
`timescale 1ns / 1ps
`default_nettype none

module ekls_quad_decoder
    import ekls_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [1:0]        phase_now,
    output logic signed [1:0]      step_dir
);

    logic [1:0]                previous_phase_reg;
    logic [1:0]                previous_phase_next;
    logic signed [SUM_W-1:0]   transition_sum_reg;
    logic signed [SUM_W-1:0]   transition_sum_next;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [1:0]         delta;

    // accumulate the table step, saturate, check for a detent on return to rest
    always_comb begin
        delta               = trans_delta(previous_phase_reg, phase_now);
        sum_wide            = {transition_sum_reg[SUM_W-1], transition_sum_reg}
                            + {{(SUM_W-1){delta[1]}}, delta};
        previous_phase_next = previous_phase_reg;
        transition_sum_next = transition_sum_reg;
        step_dir            = DIR_NONE;
        if (phase_now != previous_phase_reg) begin
            previous_phase_next = phase_now;
            if (sum_wide > SUM_MAX) begin
                transition_sum_next = SUM_MAX[SUM_W-1:0];
            end else if (sum_wide < SUM_MIN) begin
                transition_sum_next = SUM_MIN[SUM_W-1:0];
            end else begin
                transition_sum_next = sum_wide[SUM_W-1:0];
            end
            if (phase_now == PHASE_REST) begin
                if (transition_sum_next == DETENT_CW) begin
                    step_dir = DIR_CW;
                end else if (transition_sum_next == DETENT_CCW) begin
                    step_dir = DIR_CCW;
                end
                transition_sum_next = '0;
            end
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_phase_reg <= PHASE_REST;
            transition_sum_reg <= '0;
        end else if (advance) begin
            previous_phase_reg <= previous_phase_next;
            transition_sum_reg <= transition_sum_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ekls_level_ctrl.sv
// mode toggle, selection index and clamped level update for the four leds
`timescale 1ns / 1ps
`default_nettype none

module ekls_level_ctrl
    import ekls_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire logic signed [1:0]  step_dir,
    input  wire logic               button_press,
    input  wire logic [CFG_W-1:0]   step_size,
    input  wire logic [CFG_W-1:0]   max_level,
    output knob_status_t            status_next
);

    knob_status_t           status_reg;
    logic [LEVEL_W-1:0]     sel_level;
    logic [LEVEL_W:0]       up_sum;
    logic [LEVEL_W-1:0]     up_val;
    logic [LEVEL_W-1:0]     down_diff;
    logic [LEVEL_W-1:0]     down_val;

    // candidate levels for both directions, clamped to 0..max_level
    always_comb begin
        sel_level = status_reg.levels[status_reg.selection];
        up_sum    = {1'b0, sel_level} + {1'b0, step_size};
        down_diff = (sel_level < step_size) ? '0 : (sel_level - step_size);
        up_val    = (up_sum > {1'b0, max_level}) ? max_level : up_sum[LEVEL_W-1:0];
        down_val  = (down_diff > max_level) ? max_level : down_diff;
    end

    // next status: press toggles first, then the detent applies
    always_comb begin
        status_next           = status_reg;
        status_next.menu_mode = status_reg.menu_mode ^ button_press;
        if (step_dir != DIR_NONE) begin
            if (status_next.menu_mode) begin
                status_next.selection = status_reg.selection + {step_dir[1], 1'b1};
            end else if (step_dir == DIR_CW) begin
                status_next.levels[status_reg.selection] = up_val;
            end else begin
                status_next.levels[status_reg.selection] = down_val;
            end
        end
    end

    // knob status state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg.menu_mode <= 1'b1;
            status_reg.selection <= '0;
            status_reg.levels    <= '0;
        end else if (advance) begin
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/encoder_knob_level_selector.sv
// top level of the encoder knob level selector: input stage, config registers, result stage
//
//  channel   dir  width  fields (lowest bit up)
//  s_axis    in   8      phase_a, phase_b, button_press, zero pad
//  m_axis    out  40     step_direction[2], menu_mode, selected_led[2],
//                        level_zero..level_three[7 each], zero pad
//  cfg       in   7      index 0 step_size, index 1 max_level
//
//  one sample per cycle sustained while results are taken; a sample passes through the input
//  register, then the result register after the decode/update logic
//  synchronous active-low reset; all knob state returns to rest, menu mode, levels zero
//  a held result stalls the input register, which then holds off s_tready
`timescale 1ns / 1ps
`default_nettype none

module encoder_knob_level_selector
    import ekls_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // phase_a, phase_b, button_press, zero pad
    input  wire logic [IN_W-1:0]    s_tdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // step_direction, menu_mode, selected_led, level_zero..level_three, zero pad
    output logic [OUT_W-1:0]        m_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);

    logic                   in_valid_reg;
    logic [2:0]             in_data_reg;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [OUT_W-1:0]       m_tdata_next;
    logic [CFG_W-1:0]       step_size_reg;
    logic [CFG_W-1:0]       max_level_reg;
    logic                   advance;
    logic signed [1:0]      step_dir;
    knob_status_t           status_next;

    // an item moves into the result register when that register is free or draining
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_SIZE_RST;
            max_level_reg <= MAX_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_STEP_SIZE: step_size_reg <= cfg_wdata;
                CFG_MAX_LEVEL: max_level_reg <= cfg_wdata;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[2:0];
        end
    end

    ekls_quad_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .phase_now ({in_data_reg[0], in_data_reg[1]}),
        .step_dir  (step_dir)
    );

    ekls_level_ctrl u_level_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .step_dir     (step_dir),
        .button_press (in_data_reg[2]),
        .step_size    (step_size_reg),
        .max_level    (max_level_reg),
        .status_next  (status_next)
    );

    // result packing and handshake
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        m_tdata_next = {7'b0,
                        status_next.levels[3], status_next.levels[2],
                        status_next.levels[1], status_next.levels[0],
                        status_next.selection, status_next.menu_mode, step_dir};
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ekls_checker.sv
// port-level checks for the encoder knob level selector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ekls_checker
    import ekls_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [OUT_W-1:0]   m_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready
);

    // reset leaves no result pending
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // direction code never takes the unused pattern
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'b10)
        else $error("bad step direction code");

    // a fresh result follows an input transfer through the input and result registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an input transfer");

endmodule

bind encoder_knob_level_selector ekls_checker u_ekls_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
);

`default_nettype wire

>>> tb/encoder_knob_level_selector_tb.sv
// self-checking stream testbench for the encoder knob level selector
`timescale 1ns / 1ps

module encoder_knob_level_selector_tb;
    import ekls_pkg::*;

    localparam int RST_CYCLES     = 11;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 125;
    localparam int NUM_PHASES     = 8;
    localparam int DRAIN_CYCLES   = 8;

    // one pin sample as offered to the block
    typedef struct packed {
        logic a;
        logic b;
        logic press;
    } pin_sample_t;

    // one knob status word as expected back
    typedef struct packed {
        logic signed [1:0]                  dir;
        logic                               menu;
        logic [SEL_W-1:0]                   sel;
        logic [NUM_LEDS-1:0][LEVEL_W-1:0]   lvl;
    } knob_result_t;

    logic               aclk;
    logic               aresetn;
    logic [IN_W-1:0]    s_tdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic               cfg_wr_en;
    logic               cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;

    encoder_knob_level_selector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // pin samples waiting to be offered, status words waiting to arrive
    pin_sample_t    sample_q[$];
    knob_result_t   status_q[$];
    int             queued_cnt;
    int             taken_cnt;
    int             err_count;
    bit             s_taken;

    // knob state mirror
    logic [1:0]     prev_pair;
    int             quad_sum;
    bit             menu_on;
    logic [SEL_W-1:0] sel_idx;
    int             led_lvl [NUM_LEDS];
    int             step_cfg;
    int             max_cfg;

    // sender and receiver pacing
    int             burst_left;
    int             gap_left;
    int             hold_req;
    int             hold_seen;
    int             hold_left;
    int             rx_mode;
    int             mode_left;
    int             idle_cycles;
    pin_sample_t    next_smp;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // decode one sample and update the knob mirror, returning the status word
    function automatic knob_result_t advance_knob(pin_sample_t smp);
        logic [1:0]   pair;
        int           dir;
        int           lv;
        knob_result_t res;
        pair = {smp.a, smp.b};
        dir  = 0;
        if (pair != prev_pair) begin
            // gray-code transitions count one way or the other, diagonal jumps count nothing
            case ({prev_pair, pair})
                4'b0001, 4'b0111, 4'b1000, 4'b1110: quad_sum = quad_sum + 1;
                4'b0010, 4'b0100, 4'b1011, 4'b1101: quad_sum = quad_sum - 1;
                default: ;
            endcase
            if (quad_sum > 7) quad_sum = 7;
            if (quad_sum < -8) quad_sum = -8;
            if (pair == PHASE_REST) begin
                if (quad_sum == 4) dir = 1;
                else if (quad_sum == -4) dir = -1;
                quad_sum = 0;
            end
            prev_pair = pair;
        end
        // mode toggle lands before the detent
        if (smp.press) menu_on = !menu_on;
        if (dir != 0) begin
            if (menu_on) begin
                sel_idx = sel_idx + ((dir > 0) ? 2'd1 : 2'd3);
            end else begin
                lv = led_lvl[sel_idx] + dir * step_cfg;
                if (lv > max_cfg) lv = max_cfg;
                else if (lv < 0) lv = 0;
                led_lvl[sel_idx] = lv;
            end
        end
        res.dir  = (dir > 0) ? DIR_CW : (dir < 0) ? DIR_CCW : DIR_NONE;
        res.menu = menu_on;
        res.sel  = sel_idx;
        for (int i = 0; i < NUM_LEDS; i++) res.lvl[i] = LEVEL_W'(led_lvl[i]);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // compare one status word with the oldest expectation
    task automatic check_status(input logic [OUT_W-1:0] word);
        knob_result_t want;
        if (status_q.size() == 0) begin
            report_mismatch("status word with nothing pending", word, 0);
            return;
        end
        want = status_q.pop_front();
        if (word[1:0] !== want.dir) report_mismatch("step_direction", word[1:0], want.dir);
        if (word[2] !== want.menu) report_mismatch("menu_mode", word[2], want.menu);
        if (word[4:3] !== want.sel) report_mismatch("selected_led", word[4:3], want.sel);
        for (int i = 0; i < NUM_LEDS; i++) begin
            if (word[5 + LEVEL_W*i +: LEVEL_W] !== want.lvl[i])
                report_mismatch($sformatf("level of led %0d", i),
                                word[5 + LEVEL_W*i +: LEVEL_W], want.lvl[i]);
        end
        if (word[OUT_W-1:5 + LEVEL_W*NUM_LEDS] !== '0)
            report_mismatch("pad bits", word[OUT_W-1:5 + LEVEL_W*NUM_LEDS], 0);
    endtask

    // transfers on both channels, prediction, checking and the watchdog
    always @(posedge aclk) begin
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) begin
            status_q.push_back(advance_knob('{a: s_tdata[0], b: s_tdata[1], press: s_tdata[2]}));
            taken_cnt++;
        end
        if (aresetn && m_tvalid && m_tready) check_status(m_tdata);
        if (s_taken || (m_tvalid && m_tready) ||
            (taken_cnt == queued_cnt && status_q.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAIL encoder_knob_level_selector");
                $finish;
            end
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                next_smp = sample_q.pop_front();
                s_tdata  <= {{(IN_W-3){1'b0}}, next_smp.press, next_smp.b, next_smp.a};
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic push_pair(input logic [1:0] pair, input bit press);
        sample_q.push_back('{a: pair[1], b: pair[0], press: press});
        queued_cnt++;
    endtask

    // pair at position k of one detent, starting from rest
    function automatic logic [1:0] turn_pair(input bit cw, input int k);
        logic [1:0] pair;
        case (k)
            0: pair = cw ? 2'd2 : 2'd1;
            1: pair = 2'd0;
            2: pair = cw ? 2'd1 : 2'd2;
            default: pair = PHASE_REST;
        endcase
        return pair;
    endfunction

    // walk part or all of a detent; a partial walk backs out to rest
    task automatic push_turn(input bit cw, input int steps, input bit noisy, input int press_at);
        int n;
        n = 0;
        for (int k = 0; k < steps; k++) begin
            push_pair(turn_pair(cw, k), n == press_at || (noisy && $urandom_range(0, 9) == 0));
            n++;
            if (noisy && $urandom_range(0, 3) == 0) push_pair(turn_pair(cw, k), 1'b0);
        end
        if (steps < 4) begin
            for (int k = steps - 2; k >= 0; k--) begin
                push_pair(turn_pair(cw, k), noisy && $urandom_range(0, 9) == 0);
            end
            push_pair(PHASE_REST, 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (taken_cnt != queued_cnt || status_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_W'(value);
        if (addr == CFG_STEP_SIZE) step_cfg = value;
        else max_cfg = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // random mix: mostly clean detents, some partial turns and pin noise
    task automatic push_random_phase(input int items);
        int start;
        int r;
        start = queued_cnt;
        while (queued_cnt - start < items) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                repeat ($urandom_range(1, 6))
                    push_pair(2'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
            end else if (r == 1) begin
                push_turn(1'($urandom_range(0, 1)), $urandom_range(1, 3), 1'b1, -1);
            end else begin
                push_turn(1'($urandom_range(0, 1)), 4, 1'b1, -1);
            end
        end
    endtask

    initial begin
        int step_val;
        int max_val;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_STEP_SIZE;
        cfg_wdata   = '0;
        s_taken     = 1'b0;
        queued_cnt  = 0;
        taken_cnt   = 0;
        err_count   = 0;
        burst_left  = 0;
        gap_left    = 0;
        hold_req    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        rx_mode     = 0;
        mode_left   = 0;
        idle_cycles = 0;
        prev_pair   = PHASE_REST;
        quad_sum    = 0;
        menu_on     = 1'b1;
        sel_idx     = '0;
        for (int i = 0; i < NUM_LEDS; i++) led_lvl[i] = 0;
        step_cfg    = STEP_SIZE_RST;
        max_cfg     = MAX_LEVEL_RST;

        repeat (RST_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: menu moves both ways with wrap from zero
        push_turn(1'b1, 4, 1'b0, -1);
        push_turn(1'b0, 4, 1'b0, -1);
        push_turn(1'b0, 4, 1'b0, -1);
        // press on the last sample enters adjust mode before the detent applies
        push_turn(1'b1, 4, 1'b0, 3);
        // diagonal jumps add nothing
        push_pair(2'd0, 1'b0);
        push_pair(PHASE_REST, 1'b0);
        // half step and straight back
        push_turn(1'b1, 1, 1'b0, -1);
        // repeated loop through 2, 0, 1 saturates the accumulator, no false detent
        push_pair(2'd2, 1'b0);
        repeat (3) begin
            push_pair(2'd0, 1'b0);
            push_pair(2'd1, 1'b0);
            push_pair(2'd2, 1'b0);
        end
        push_pair(2'd0, 1'b0);
        push_pair(2'd1, 1'b0);
        push_pair(PHASE_REST, 1'b1);
        wait_drained();

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin step_val = 1;   max_val = 127; end
                1: begin step_val = 127; max_val = 127; end
                2: begin step_val = 0;   max_val = 60;  end
                3: begin step_val = 100; max_val = 1;   end
                4: begin step_val = 5;   max_val = 0;   end
                7: begin step_val = STEP_SIZE_RST; max_val = MAX_LEVEL_RST; end
                default: begin
                    step_val = $urandom_range(0, 127);
                    max_val  = $urandom_range(0, 127);
                end
            endcase
            write_reg(CFG_STEP_SIZE, step_val);
            write_reg(CFG_MAX_LEVEL, max_val);
            push_random_phase(PHASE_ITEMS);
            // long receiver hold-off while the sender keeps offering
            if (ph == 2 || ph == 5) hold_req++;
            wait_drained();
        end

        if (err_count == 0) begin
            $display("PASS encoder_knob_level_selector");
        end else begin
            $display("FAIL encoder_knob_level_selector");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/ekls_pkg.sv
hdl/ekls_quad_decoder.sv
hdl/ekls_level_ctrl.sv
hdl/encoder_knob_level_selector.sv
hdl/ekls_checker.sv
tb/encoder_knob_level_selector_tb.sv
